@@ design/nearest_palette_colour_snap_top_assert.svh @@
// Assertion macros shared by the nearest palette colour snap RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef NEAREST_PALETTE_COLOUR_SNAP_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOUR_SNAP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nps assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nps assertion failed");

`endif

@@ design/nps_pkg.sv @@
// Shared types and constants for the nearest palette colour snap block.
// No dependencies; used by nps_ctrl, nps_datapath and the top level.
package nps_pkg;

   localparam int PALETTE_DEPTH = 128;   // default palette size
   localparam int COLOUR_W      = 15;    // RGB555 entry
   localparam int COUNT_W       = 9;     // holds a count up to 511
   localparam int DIST_W        = 12;    // 3 * 31^2 = 2883 fits

   // Above any reachable distance, so the first entry always wins.
   localparam logic [DIST_W-1:0] FAR_DISTANCE = '1;

   // Transaction kinds on req_cmd.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic wr_en;     // store req_entry_colour at req_entry_index
      logic load;      // latch quantized pixel, reset best match
      logic rd_en;     // read palette entry at rd_addr
      logic pass_out;  // emit the input colour unchanged
      logic snap_out;  // emit the best match
   } dp_cmd_type;

endpackage

@@ design/nps_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module nps_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/nps_ctrl.sv @@
// Controller for the nearest palette colour snap: handshake, count register
// and palette sweep sequencing. Depends on nps_pkg and the assertion header.
`include "nearest_palette_colour_snap_top_assert.svh"

module nps_ctrl #(
   parameter int PALETTE_DEPTH = nps_pkg::PALETTE_DEPTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_cmd,
   input  logic [6:0]                               req_entry_index,
   input  logic                                     req_opaque_in,
   input  logic                                     csr_we,
   input  logic [7:0]                               csr_wdata,
   output nps_pkg::dp_cmd_type                      dp_cmd,
   output logic [((PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1)-1:0] rd_addr,
   input  logic                                     pipe_busy
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CW = nps_pkg::COUNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

   nps_pkg::state_type state_ff, state_in;
   logic [7:0]         count_ff;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [CW-1:0]      count_ext;
   logic [CW-1:0]      eff_count;
   logic [AW-1:0]      last_addr;
   logic               accept;

   // Count saturates at the palette depth.
   assign count_ext = {1'b0, count_ff};
   assign eff_count = (count_ext > DEPTH_C) ? DEPTH_C : count_ext;
   assign last_addr = AW'(eff_count - CW'(1));

   assign busy    = (state_ff != nps_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign rd_addr = addr_ff;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      dp_cmd   = '0;
      case (state_ff)
         nps_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == nps_pkg::CMD_WRITE) begin
                  // out-of-range slots are dropped
                  dp_cmd.wr_en = (CW'(req_entry_index) < DEPTH_C);
               end else if (!req_opaque_in || (eff_count == '0)) begin
                  dp_cmd.pass_out = 1'b1;
               end else begin
                  dp_cmd.load = 1'b1;
                  addr_in     = '0;
                  state_in    = nps_pkg::ST_SWEEP;
               end
            end
         end
         nps_pkg::ST_SWEEP: begin
            dp_cmd.rd_en = 1'b1;
            if (addr_ff == last_addr) begin
               state_in = nps_pkg::ST_DRAIN;
            end else begin
               addr_in = AW'(addr_ff + 1'b1);
            end
         end
         nps_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               dp_cmd.snap_out = 1'b1;
               state_in        = nps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nps_pkg::ST_IDLE;
         count_ff <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   // Sweep never reads past the last valid entry.
   `NPS_ASSERT_NOW(a_rd_in_range, dp_cmd.rd_en, rd_addr <= last_addr)
   // Best match is only taken once the compare pipeline has emptied.
   `NPS_ASSERT_NOW(a_snap_after_drain, dp_cmd.snap_out, !pipe_busy)
   // An opaque pixel with a nonzero palette always starts a sweep.
   `NPS_ASSERT_NEXT(a_pixel_sweeps,
      accept && (req_cmd == nps_pkg::CMD_PIXEL) && req_opaque_in && (eff_count != '0),
      state_ff == nps_pkg::ST_SWEEP)

endmodule

@@ design/nps_datapath.sv @@
// Datapath for the nearest palette colour snap: palette RAM, quantizer,
// distance pipeline, best-match tracking and result registers.
// Depends on nps_pkg, nps_ram and the assertion header.
`include "nearest_palette_colour_snap_top_assert.svh"

module nps_datapath #(
   parameter int PALETTE_DEPTH = nps_pkg::PALETTE_DEPTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  nps_pkg::dp_cmd_type                      dp_cmd,
   input  logic [((PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1)-1:0] rd_addr,
   output logic                                     pipe_busy,
   input  logic [6:0]                               req_entry_index,
   input  logic [14:0]                              req_entry_colour,
   input  logic [7:0]                               req_red_in,
   input  logic [7:0]                               req_green_in,
   input  logic [7:0]                               req_blue_in,
   output logic                                     rsp_valid,
   output logic [7:0]                               rsp_red_out,
   output logic [7:0]                               rsp_green_out,
   output logic [7:0]                               rsp_blue_out,
   output logic [6:0]                               rsp_matched_index,
   output logic                                     rsp_snapped
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CLW = nps_pkg::COLOUR_W;
   localparam int DW  = nps_pkg::DIST_W;

   // v5 * 255 / 31, rounded down
   localparam logic [7:0] EXPAND8 [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   // (v*31 + 127) / 255; x/255 == (x + (x>>8) + 1) >> 8 for x below 65535
   function automatic logic [4:0] quantize5(input logic [7:0] v);
      logic [12:0] x;
      logic [13:0] y;
      x = 13'({5'b0, v} * 13'd31) + 13'd127;
      y = {1'b0, x} + 14'(x >> 8) + 14'd1;
      return y[12:8];
   endfunction

   function automatic logic [9:0] gap_sq(input logic [4:0] a, input logic [4:0] b);
      logic [4:0] d;
      d = (a > b) ? 5'(a - b) : 5'(b - a);
      return 10'({5'b0, d} * {5'b0, d});
   endfunction

   logic [CLW-1:0] rd_data;
   logic [4:0]     wr_ff, wg_ff, wb_ff;
   logic           rd_valid_ff, dist_valid_ff, rsp_valid_ff;
   logic [AW-1:0]  rd_idx_ff, dist_idx_ff, best_i_ff;
   logic [DW-1:0]  dist_ff, dist_in, best_d_ff;
   logic [CLW-1:0] dist_col_ff, best_c_ff;
   logic [7:0]     red_ff, green_ff, blue_ff;
   logic [6:0]     index_ff;
   logic           snapped_ff;

   nps_ram #(
      .WIDTH (CLW),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (dp_cmd.wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_entry_colour),
      .rd_en   (dp_cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign dist_in = DW'(gap_sq(wr_ff, rd_data[4:0]))
                  + DW'(gap_sq(wg_ff, rd_data[9:5]))
                  + DW'(gap_sq(wb_ff, rd_data[14:10]));

   assign pipe_busy = rd_valid_ff || dist_valid_ff;

   // Control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         dist_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= dp_cmd.rd_en;
         dist_valid_ff <= rd_valid_ff;
         rsp_valid_ff  <= dp_cmd.pass_out || dp_cmd.snap_out;
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         wr_ff     <= quantize5(req_red_in);
         wg_ff     <= quantize5(req_green_in);
         wb_ff     <= quantize5(req_blue_in);
         best_d_ff <= nps_pkg::FAR_DISTANCE;
         best_i_ff <= '0;
      end else if (dist_valid_ff && (dist_ff < best_d_ff)) begin
         // strict compare keeps the lowest index on a tie
         best_d_ff <= dist_ff;
         best_i_ff <= dist_idx_ff;
         best_c_ff <= dist_col_ff;
      end
      if (dp_cmd.rd_en) begin
         rd_idx_ff <= rd_addr;
      end
      if (rd_valid_ff) begin
         dist_ff     <= dist_in;
         dist_idx_ff <= rd_idx_ff;
         dist_col_ff <= rd_data;
      end
      if (dp_cmd.pass_out) begin
         red_ff     <= req_red_in;
         green_ff   <= req_green_in;
         blue_ff    <= req_blue_in;
         index_ff   <= '0;
         snapped_ff <= 1'b0;
      end else if (dp_cmd.snap_out) begin
         red_ff     <= EXPAND8[best_c_ff[4:0]];
         green_ff   <= EXPAND8[best_c_ff[9:5]];
         blue_ff    <= EXPAND8[best_c_ff[14:10]];
         index_ff   <= 7'(best_i_ff);
         snapped_ff <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_out       = red_ff;
   assign rsp_green_out     = green_ff;
   assign rsp_blue_out      = blue_ff;
   assign rsp_matched_index = index_ff;
   assign rsp_snapped       = snapped_ff;

   // Every result strobe follows exactly one output command.
   `NPS_ASSERT_NEXT(a_strobe_follows_cmd, dp_cmd.pass_out || dp_cmd.snap_out, rsp_valid_ff)
   // Reads and loads never collide with a result being formed.
   `NPS_ASSERT_NOW(a_no_read_on_output,
      dp_cmd.pass_out || dp_cmd.snap_out, !dp_cmd.rd_en && !dp_cmd.load)

endmodule

@@ design/nearest_palette_colour_snap_top.sv @@
// Nearest palette colour snap, top level. Palette write: no result, busy stays low.
// Pixel, transparent or palette count zero: result strobed the cycle after start.
// Pixel, opaque: result strobed as busy falls; busy while palette slots 0 to N-1
// are read, one per cycle, and the pipeline drains; N is the saturated palette count.
// Reset (synchronous, active high) clears the count to 0 and the controller to idle;
// palette RAM contents are kept and are undefined until written. No result stall.
module nearest_palette_colour_snap_top #(
   parameter int PALETTE_DEPTH = nps_pkg::PALETTE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request transaction: accepted when start is high and busy is low
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [6:0]  req_entry_index,
   input  logic [14:0] req_entry_colour,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic        req_opaque_in,
   // response transaction: valid for exactly one cycle, cannot be held off
   output logic        rsp_valid,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [6:0]  rsp_matched_index,
   output logic        rsp_snapped,
   // palette count register, write only; change it only while idle
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   nps_pkg::dp_cmd_type dp_cmd;
   logic [AW-1:0]       rd_addr;
   logic                pipe_busy;

   // Controller: owns the count register, the handshake and the sweep
   // address counter. It issues one palette read per cycle from slot 0
   // up to count-1, then waits for the distance pipeline to empty.
   nps_ctrl #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_opaque_in   (req_opaque_in),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .dp_cmd          (dp_cmd),
      .rd_addr         (rd_addr),
      .pipe_busy       (pipe_busy)
   );

   // Datapath: palette RAM (registered read), quantize to RGB555, a
   // registered squared-distance stage, then a strict less-than compare
   // so the lowest slot wins a tie. Results leave through output registers,
   // so a new transaction can be taken while a result is on the ports.
   nps_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .rd_addr           (rd_addr),
      .pipe_busy         (pipe_busy),
      .req_entry_index   (req_entry_index),
      .req_entry_colour  (req_entry_colour),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_matched_index (rsp_matched_index),
      .rsp_snapped       (rsp_snapped)
   );

endmodule

@@ verif/palette_snap_scoreboard_pkg.sv @@
// Scoreboard for the nearest palette colour snap testbench: mirrors the palette
// and count, predicts every pixel transaction and checks strobed results.
// Depends on nps_pkg for widths, depth and transaction kinds.
package palette_snap_scoreboard_pkg;
   import nps_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [6:0] index;
      logic       snapped;
   } snap_result_type;

   localparam int unsigned NO_MATCH_DISTANCE = 1 << 30;
   localparam int MISMATCH_REPORTS = 10;

   class palette_snap_scoreboard;
      logic [COLOUR_W-1:0] palette [PALETTE_DEPTH];
      logic [7:0]          palette_count;
      snap_result_type     expected_snaps [$];
      int                  mismatch_count;

      function new();
         palette_count = 8'd0;
         mismatch_count = 0;
         foreach (palette[i]) palette[i] = '0;
      endfunction

      // count saturates at the table depth
      function int active_entries();
         return (palette_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(palette_count);
      endfunction

      function logic [4:0] to_five_bits(logic [7:0] v);
         int unsigned t;
         t = v;
         return 5'((t * 31 + 127) / 255);
      endfunction

      function logic [7:0] to_eight_bits(logic [4:0] v);
         int unsigned t;
         t = v;
         return 8'((t * 255) / 31);
      endfunction

      function int unsigned gap_sq(logic [4:0] a, logic [4:0] b);
         int unsigned d;
         d = (a > b) ? int'(a - b) : int'(b - a);
         return d * d;
      endfunction

      function snap_result_type predict_snap(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             logic opaque);
         snap_result_type res;
         int unsigned     best_distance;
         int unsigned     distance;
         int              best_slot;
         int              n;
         logic [4:0]      qr, qg, qb;
         logic [14:0]     hit;
         n = active_entries();
         res.red = r;
         res.green = g;
         res.blue = b;
         res.index = '0;
         res.snapped = 1'b0;
         if (!opaque || n == 0) return res;
         qr = to_five_bits(r);
         qg = to_five_bits(g);
         qb = to_five_bits(b);
         best_distance = NO_MATCH_DISTANCE;
         best_slot = 0;
         for (int i = 0; i < n; i++) begin
            distance = gap_sq(qr, palette[i][4:0]) + gap_sq(qg, palette[i][9:5])
                     + gap_sq(qb, palette[i][14:10]);
            // strict less-than keeps the lowest slot on a tie
            if (distance < best_distance) begin
               best_distance = distance;
               best_slot = i;
            end
         end
         hit = palette[best_slot];
         res.red = to_eight_bits(hit[4:0]);
         res.green = to_eight_bits(hit[9:5]);
         res.blue = to_eight_bits(hit[14:10]);
         res.index = 7'(best_slot);
         res.snapped = 1'b1;
         return res;
      endfunction

      function void note_count(logic [7:0] value);
         palette_count = value;
      endfunction

      function void note_request(logic cmd, logic [6:0] index, logic [14:0] colour,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic opaque);
         if (cmd == CMD_WRITE) begin
            if (index < PALETTE_DEPTH) palette[index] = colour;
         end else begin
            expected_snaps = {expected_snaps, predict_snap(r, g, b, opaque)};
         end
      endfunction

      function void check_result(snap_result_type got);
         snap_result_type want;
         if (expected_snaps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_REPORTS)
               $display("unexpected result: r=%0d g=%0d b=%0d index=%0d snapped=%0b",
                        got.red, got.green, got.blue, got.index, got.snapped);
            return;
         end
         want = expected_snaps.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
             || got.index !== want.index || got.snapped !== want.snapped) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_REPORTS)
               $display("mismatch: expected r=%0d g=%0d b=%0d index=%0d snapped=%0b,",
                        want.red, want.green, want.blue, want.index, want.snapped,
                        " got r=%0d g=%0d b=%0d index=%0d snapped=%0b",
                        got.red, got.green, got.blue, got.index, got.snapped);
         end
      endfunction
   endclass

endpackage

@@ verif/nearest_palette_colour_snap_top_tb.sv @@
// Self-checking testbench for nearest_palette_colour_snap_top: directed corner
// pixels, then bursty random palette writes and pixels across several counts.
// Depends on nps_pkg and palette_snap_scoreboard_pkg.
module nearest_palette_colour_snap_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nps_pkg::*;
   import palette_snap_scoreboard_pkg::*;

   localparam int RESET_CYCLES  = 12;
   // slowest run is roughly 1850 transactions, each up to a full sweep plus a gap
   localparam int CYCLE_LIMIT   = 1_500_000;
   // a sweep has ended once its result is out; a few spare cycles before CSR writes
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 142;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [6:0]  req_entry_index;
   logic [14:0] req_entry_colour;
   logic [7:0]  req_red_in;
   logic [7:0]  req_green_in;
   logic [7:0]  req_blue_in;
   logic        req_opaque_in;
   logic        rsp_valid;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [6:0]  rsp_matched_index;
   logic        rsp_snapped;
   logic        csr_we;
   logic [7:0]  csr_wdata;

   palette_snap_scoreboard snap_board;
   int unsigned            cycle_count = 0;

   // Count settings per random phase: extremes (0, 1, full depth, above depth,
   // all-ones) mixed with small and mid-range counts.
   int phase_counts [12] = '{1, 128, 2, 255, 129, 0, 16, 3, 64, 127, 8, 200};

   nearest_palette_colour_snap_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_entry_index   (req_entry_index),
      .req_entry_colour  (req_entry_colour),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .req_opaque_in     (req_opaque_in),
      .rsp_valid         (rsp_valid),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_matched_index (rsp_matched_index),
      .rsp_snapped       (rsp_snapped),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Monitor: everything is sampled at the rising edge, before any register
   // update lands, so the view matches what the DUT itself samples.
   always @(posedge clock) begin
      if (!reset) begin
         // a result can never belong to a transaction accepted on this same edge
         if (rsp_valid)
            snap_board.check_result('{rsp_red_out, rsp_green_out, rsp_blue_out,
                                      rsp_matched_index, rsp_snapped});
         if (start && !busy)
            snap_board.note_request(req_cmd, req_entry_index, req_entry_colour,
                                    req_red_in, req_green_in, req_blue_in, req_opaque_in);
         if (csr_we)
            snap_board.note_count(csr_wdata);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nearest_palette_colour_snap_top_tb: FAIL");
         $finish;
      end
   end

   // Drive one transaction from the falling edge and hold it until accepted.
   // start is left high so a following transaction can go back to back.
   task automatic send_item(logic cmd, logic [6:0] index, logic [14:0] colour,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b, logic opaque);
      @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_entry_index = index;
      req_entry_colour = colour;
      req_red_in = r;
      req_green_in = g;
      req_blue_in = b;
      req_opaque_in = opaque;
      do @(posedge clock); while (busy);
   endtask

   // Unused fields carry random values; the DUT must ignore them.
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic opaque);
      send_item(CMD_PIXEL, 7'($urandom), 15'($urandom), r, g, b, opaque);
   endtask

   task automatic send_entry(logic [6:0] index, logic [14:0] colour);
      send_item(CMD_WRITE, index, colour, 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
   endtask

   task automatic pause_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Sender holds off until every expected result is back and the sweep is done.
   task automatic wait_quiet();
      @(negedge clock);
      start = 1'b0;
      while (busy || snap_board.expected_snaps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(logic [7:0] value);
      wait_quiet();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Random pixel: half the time aimed near a live palette entry so the nearest-match
   // search has close competitors, plus saturated corners and plain noise.
   task automatic send_random_pixel();
      int          n;
      int          mode;
      int          level;
      logic [7:0]  chan [3];
      logic [14:0] aim;
      n = snap_board.active_entries();
      mode = $urandom_range(0, 9);
      foreach (chan[c]) chan[c] = 8'($urandom);
      if (mode == 0) begin
         foreach (chan[c]) chan[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else if (mode <= 5 && n > 0) begin
         aim = snap_board.palette[$urandom_range(0, n - 1)];
         foreach (chan[c]) begin
            level = (int'(aim[c*5 +: 5]) * 255) / 31 + int'($urandom_range(0, 12)) - 6;
            chan[c] = (level < 0) ? 8'd0 : (level > 255) ? 8'd255 : 8'(level);
         end
      end
      send_pixel(chan[0], chan[1], chan[2], $urandom_range(0, 7) != 0);
   endtask

   // Random palette write: duplicates of existing entries force index ties.
   task automatic send_random_entry();
      int          mode;
      logic [14:0] colour;
      mode = $urandom_range(0, 7);
      if (mode < 2)
         colour = snap_board.palette[$urandom_range(0, PALETTE_DEPTH - 1)];
      else if (mode == 2)
         colour = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
      else
         colour = 15'($urandom);
      send_entry(7'($urandom), colour);
   endtask

   // Bursts of random length, separated by random gaps (sometimes none).
   task automatic run_bursts(int items);
      int remaining;
      int burst;
      remaining = items;
      while (remaining > 0) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && remaining > 0) begin
            if ($urandom_range(0, 3) == 0) send_random_entry();
            else send_random_pixel();
            burst--;
            remaining--;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      end
   endtask

   initial begin
      logic [14:0] colour;
      snap_board = new();
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_WRITE;
      req_entry_index = '0;
      req_entry_colour = '0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_opaque_in = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Count is zero out of reset: opaque pixels pass straight through.
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);

      // Load every slot so no sweep ever reads an unwritten entry.
      // Slots 0..5 and 127 hold hand-picked colours for the corner checks below.
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
         case (i)
            0:       colour = 15'h0000;   // black
            1:       colour = 15'h7FFF;   // white
            2:       colour = 15'h000A;   // red 10
            3:       colour = 15'h000C;   // red 12, equidistant from red 11
            4, 5:    colour = 15'h4210;   // identical mid grey pair
            127:     colour = 15'h7C1F;   // magenta, only in the last slot
            default: do colour = 15'($urandom);
                     while (colour == 15'h000B || colour == 15'h7C1F);
         endcase
         send_entry(7'(i), colour);
      end

      write_count(8'd128);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);   // exact black
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);   // exact white
      send_pixel(8'd90, 8'h00, 8'h00, 1'b1);   // red 11: tie between slots 2 and 3
      send_pixel(8'd132, 8'd132, 8'd132, 1'b1); // duplicate colours: lower slot
      send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);   // match in the highest slot
      send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);   // transparent with a live palette
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);

      // Count above the depth saturates; count of one searches slot 0 only.
      write_count(8'd255);
      send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
      write_count(8'd1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

      // Random phases, each started from an idle block.
      foreach (phase_counts[p]) begin
         write_count(8'(phase_counts[p]));
         run_bursts(PHASE_ITEMS);
      end

      wait_quiet();
      if (snap_board.mismatch_count == 0 && snap_board.expected_snaps.size() == 0) begin
         $display("nearest_palette_colour_snap_top_tb: PASS");
      end else begin
         $display("nearest_palette_colour_snap_top_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/nps_pkg.sv
design/nps_ram.sv
design/nps_ctrl.sv
design/nps_datapath.sv
design/nearest_palette_colour_snap_top.sv
verif/palette_snap_scoreboard_pkg.sv
verif/nearest_palette_colour_snap_top_tb.sv
